/* design/ple_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared codes and widths for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 8;

  typedef logic [2:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_INS_FRONT = 3'd0;
  localparam cmd_t CMD_INS_BACK  = 3'd1;
  localparam cmd_t CMD_INS_AT    = 3'd2;
  localparam cmd_t CMD_DEL_FRONT = 3'd3;
  localparam cmd_t CMD_DEL_BACK  = 3'd4;
  localparam cmd_t CMD_DEL_AT    = 3'd5;
  localparam cmd_t CMD_DUMP      = 3'd6;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_BADPOS = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_EMPTY  = 2'd3;

endpackage
`default_nettype wire

/* design/ple_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ple_mem
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ple_mem
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic signed [WORD_W-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic signed [WORD_W-1:0]              rdata
);

  logic signed [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/positional_list_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed words kept in a one-port-read RAM.
// ----------------------------------------------------------------------------
// Answers: tail inserts/deletes, no-ops and rejected commands answer in the cycle
//   after the accepting edge; any other insert or delete (head included) moves
//   one word per cycle through the RAM read/write pair.
// Dump: first word via the RAM read and output registers, then one word per cycle.
// busy drops as the last word of a command goes out; next start taken then.
// Reset (rst, synchronous): list empty, idle; RAM contents are not cleared.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [2:0]                       command,
  input  wire logic signed [WORD_W-1:0]         value,
  input  wire logic [POS_W-1:0]                 position,
  output logic                                  valid,
  output logic [1:0]                            status,
  output logic [$clog2(DEPTH+1)-1:0]            length,
  output logic signed [WORD_W-1:0]              element,
  output logic                                  last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = POS_W + 1;   // compare width for position checks

  typedef enum logic [2:0] {S_IDLE, S_INS, S_DEL, S_FIN, S_DUMP} state_t;

  state_t                   state;
  logic [CW-1:0]            count;
  logic [AW-1:0]            rp;        // RAM read pointer
  logic [AW-1:0]            wa;        // write address for the word in flight
  logic [AW-1:0]            idx;       // target slot
  logic signed [WORD_W-1:0] val;
  logic                     is_ins;
  logic                     pend;      // RAM read data valid this cycle
  logic                     pend_last;
  logic                     rd_done;

  logic                     mem_we;
  logic [AW-1:0]            mem_wa;
  logic signed [WORD_W-1:0] mem_wd;
  logic signed [WORD_W-1:0] rdata;

  logic [AW-1:0]            ins_idx;
  logic [AW-1:0]            del_idx;
  logic                     ins_bad;
  logic                     del_bad;
  logic                     accept;
  logic [XW-1:0]            pos_x;
  logic [XW-1:0]            cnt_x;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pos_x  = XW'(position);
  assign cnt_x  = XW'(count);

  // Position decode: 1-based position to 0-based slot
  always_comb begin
    case (command)
      CMD_INS_FRONT: ins_idx = '0;
      CMD_INS_BACK:  ins_idx = AW'(count);
      default:       ins_idx = AW'(position - POS_W'(1));
    endcase
    case (command)
      CMD_DEL_FRONT: del_idx = '0;
      CMD_DEL_BACK:  del_idx = AW'(count - CW'(1));
      default:       del_idx = AW'(position - POS_W'(1));
    endcase
    ins_bad = (command == CMD_INS_AT) &&
              ((position == '0) || (pos_x > cnt_x + XW'(1)));
    del_bad = (command == CMD_DEL_AT) &&
              ((position == '0) || (pos_x > cnt_x));
  end

  // RAM port steering
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx;
    mem_wd = val;
    case (state)
      S_IDLE: begin
        // append at the tail needs no move: write straight in
        if (accept && (command == CMD_INS_FRONT || command == CMD_INS_BACK ||
                       command == CMD_INS_AT) &&
            (count != CW'(DEPTH)) && !ins_bad && (CW'(ins_idx) == count)) begin
          mem_we = 1'b1;
          mem_wa = ins_idx;
          mem_wd = value;
        end
      end
      S_INS, S_DEL: begin
        mem_we = pend;
        mem_wa = wa;
        mem_wd = rdata;
      end
      S_FIN: begin
        mem_we = is_ins;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  ple_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .raddr (rp),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    valid   <= 1'b0;
    element <= '0;
    last    <= 1'b1;
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      pend_last <= 1'b0;
      rd_done   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend    <= 1'b0;
            rd_done <= 1'b0;
            length  <= count;
            case (command)
              CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
                if (count == CW'(DEPTH)) begin
                  valid  <= 1'b1;
                  status <= ST_FULL;
                end else if (ins_bad) begin
                  valid  <= 1'b1;
                  status <= ST_BADPOS;
                end else if (CW'(ins_idx) == count) begin
                  valid  <= 1'b1;
                  status <= ST_OK;
                  count  <= count + CW'(1);
                  length <= count + CW'(1);
                end else begin
                  // move tail up by one, top down
                  idx    <= ins_idx;
                  val    <= value;
                  is_ins <= 1'b1;
                  rp     <= AW'(count - CW'(1));
                  state  <= S_INS;
                end
              end
              CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
                if (count == '0) begin
                  valid  <= 1'b1;
                  status <= ST_EMPTY;
                end else if (del_bad) begin
                  valid  <= 1'b1;
                  status <= ST_BADPOS;
                end else if (CW'(del_idx) == count - CW'(1)) begin
                  valid  <= 1'b1;
                  status <= ST_OK;
                  count  <= count - CW'(1);
                  length <= count - CW'(1);
                end else begin
                  // move tail down by one, bottom up
                  idx    <= del_idx;
                  is_ins <= 1'b0;
                  rp     <= del_idx + AW'(1);
                  state  <= S_DEL;
                end
              end
              CMD_DUMP: begin
                if (count == '0) begin
                  valid  <= 1'b1;
                  status <= ST_EMPTY;
                end else begin
                  rp    <= '0;
                  state <= S_DUMP;
                end
              end
              default: begin
                valid  <= 1'b1;
                status <= ST_OK;
              end
            endcase
          end
        end
        S_INS: begin
          if (!rd_done) begin
            pend <= 1'b1;
            wa   <= rp + AW'(1);
            if (rp == idx) begin
              rd_done <= 1'b1;
            end else begin
              rp <= rp - AW'(1);
            end
          end else begin
            pend  <= 1'b0;
            state <= S_FIN;
          end
        end
        S_DEL: begin
          if (!rd_done) begin
            pend <= 1'b1;
            wa   <= rp - AW'(1);
            if (rp == AW'(count - CW'(1))) begin
              rd_done <= 1'b1;
            end else begin
              rp <= rp + AW'(1);
            end
          end else begin
            pend  <= 1'b0;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          valid  <= 1'b1;
          status <= ST_OK;
          if (is_ins) begin
            count  <= count + CW'(1);
            length <= count + CW'(1);
          end else begin
            count  <= count - CW'(1);
            length <= count - CW'(1);
          end
          state <= S_IDLE;
        end
        S_DUMP: begin
          if (!rd_done) begin
            pend      <= 1'b1;
            pend_last <= (rp == AW'(count - CW'(1)));
            if (rp == AW'(count - CW'(1))) begin
              rd_done <= 1'b1;
            end else begin
              rp <= rp + AW'(1);
            end
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            valid   <= 1'b1;
            status  <= ST_OK;
            length  <= count;
            element <= rdata;
            last    <= pend_last;
            if (pend_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/ple_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks on the positional list engine.
// ----------------------------------------------------------------------------
module ple_checker
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        busy,
  input wire logic                        valid,
  input wire logic [1:0]                  status,
  input wire logic [$clog2(DEPTH+1)-1:0]  length,
  input wire logic signed [WORD_W-1:0]    element,
  input wire logic                        last
);

  // length never exceeds capacity
  a_len: assert property (@(posedge clk) disable iff (rst)
    valid |-> (length <= ($clog2(DEPTH+1))'(DEPTH)))
    else $error("length above capacity");

  // a rejected command is a single word
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (valid && status != ST_OK) |-> last)
    else $error("error word without last");

  // dump words come back to back
  a_stream: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |=> valid)
    else $error("gap inside dump");

  // nonzero element only on ok words
  a_elem: assert property (@(posedge clk) disable iff (rst)
    (valid && element != 0) |-> (status == ST_OK))
    else $error("element on error word");

  // reset leaves the engine idle
  a_rst: assert property (@(posedge clk)
    rst |=> (!valid && !busy))
    else $error("not idle after reset");

endmodule

bind positional_list_engine ple_checker #(.DEPTH(DEPTH)) u_ple_checker (
  .clk     (clk),
  .rst     (rst),
  .busy    (busy),
  .valid   (valid),
  .status  (status),
  .length  (length),
  .element (element),
  .last    (last)
);
`default_nettype wire

/* sim/positional_list_engine_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_engine_tb
// Drives list commands through the start/busy port and checks every result
// word against a behavioral list kept in the bench.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int DEPTH     = 16;
  localparam int LEN_W     = $clog2(DEPTH + 1);
  localparam int N_RANDOM  = 380;
  localparam int MAX_CYCLES = 400000;
  localparam logic [2:0] CMD_NOP = 3'd7;  // unused code, answers like a no-op

  typedef struct packed {
    logic [2:0]        command;
    logic [WORD_W-1:0] value;
    logic [POS_W-1:0]  position;
  } cmd_word_t;

  typedef struct packed {
    status_t           status;
    logic [LEN_W-1:0]  length;
    logic [WORD_W-1:0] element;
    logic              last;
  } result_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] command = '0;
  logic signed [WORD_W-1:0] value = '0;
  logic [POS_W-1:0] position = '0;
  logic valid;
  logic [1:0] status;
  logic [LEN_W-1:0] length;
  logic signed [WORD_W-1:0] element;
  logic last;

  cmd_word_t    pending_cmds[$];
  result_word_t expected_words[$];

  // bench copy of the list
  logic [WORD_W-1:0] list_mem[DEPTH];
  int unsigned       list_len = 0;

  int  mismatches = 0;
  int  cycle_count = 0;
  bit  stim_done = 1'b0;
  bit  quiet_phase = 1'b0;  // long stretch with no sender gaps

  always #4 clk = ~clk;

  positional_list_engine #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .value(value), .position(position),
    .valid(valid), .status(status), .length(length),
    .element(element), .last(last)
  );

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0d: %s", cycle_count, what);
    mismatches++;
  endtask

  function automatic result_word_t make_word(status_t st, logic [WORD_W-1:0] el, logic lst);
    result_word_t r;
    r.status  = st;
    r.length  = list_len[LEN_W-1:0];
    r.element = el;
    r.last    = lst;
    return r;
  endfunction

  // Apply one accepted command to the bench list and queue its words.
  task automatic predict_list_op(input cmd_word_t c);
    status_t st;
    int unsigned idx;
    st = ST_OK;
    idx = 0;
    case (c.command)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
        if (list_len >= DEPTH) st = ST_FULL;
        else if (c.command == CMD_INS_AT &&
                 (c.position < 1 || c.position > list_len + 1)) st = ST_BADPOS;
        else begin
          if (c.command == CMD_INS_BACK) idx = list_len;
          else if (c.command == CMD_INS_AT) idx = c.position - 1;
          for (int i = list_len; i > idx; i--) list_mem[i] = list_mem[i-1];
          list_mem[idx] = c.value;
          list_len++;
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (c.command == CMD_DEL_AT &&
                 (c.position < 1 || c.position > list_len)) st = ST_BADPOS;
        else begin
          if (c.command == CMD_DEL_BACK) idx = list_len - 1;
          else if (c.command == CMD_DEL_AT) idx = c.position - 1;
          for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      CMD_DUMP: begin
        if (list_len == 0) st = ST_EMPTY;
        else begin
          for (int i = 0; i < list_len; i++)
            expected_words.push_back(make_word(ST_OK, list_mem[i], i + 1 == list_len));
          return;
        end
      end
      default: ;  // code 7: no-op
    endcase
    expected_words.push_back(make_word(st, '0, 1'b1));
  endtask

  // Driver: start stays high across back-to-back words; one NBA per step.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (start && !busy) predict_list_op('{command, value, position});
      if (!(start && busy)) begin
        // previous word taken (or none held): present next or idle
        if (pending_cmds.size() > 0 && (quiet_phase || $urandom_range(99) >= 16)) begin
          cmd_word_t c;
          c = pending_cmds.pop_front();
          start    <= 1'b1;
          command  <= c.command;
          value    <= c.value;
          position <= c.position;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && valid) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        result_word_t e;
        e = expected_words.pop_front();
        if (status !== e.status)
          report_mismatch($sformatf("status %0d exp %0d", status, e.status));
        if (length !== e.length)
          report_mismatch($sformatf("length %0d exp %0d", length, e.length));
        if (element !== e.element)
          report_mismatch($sformatf("element %h exp %h", element, e.element));
        if (last !== e.last)
          report_mismatch($sformatf("last %b exp %b", last, e.last));
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > MAX_CYCLES) begin
      $display("positional_list_engine regression: fail");
      $finish;
    end
  end

  function automatic cmd_word_t mk(logic [2:0] c, logic [WORD_W-1:0] v, logic [POS_W-1:0] p);
    cmd_word_t w;
    w.command = c; w.value = v; w.position = p;
    return w;
  endfunction

  // Random command biased to keep the list mid-filled with fair chances of
  // hitting full and empty; positions mostly near the live range.
  function automatic cmd_word_t rand_cmd(int unsigned est_len);
    logic [2:0] c;
    logic [POS_W-1:0] p;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45)      c = 3'($urandom_range(2));
    else if (r < 85) c = 3'(3 + $urandom_range(2));
    else if (r < 97) c = CMD_DUMP;
    else             c = CMD_NOP;
    r = $urandom_range(9);
    if (r < 8)      p = POS_W'($urandom_range(est_len + 2));
    else if (r < 9) p = '0;
    else            p = POS_W'($urandom);
    return mk(c, $urandom, p);
  endfunction

  initial begin
    int unsigned est;
    // directed: empty-list cases, extremes, full list, bad positions
    pending_cmds.push_back(mk(CMD_DUMP, '0, '0));
    pending_cmds.push_back(mk(CMD_DEL_FRONT, '0, '0));
    pending_cmds.push_back(mk(CMD_DEL_BACK, '0, '0));
    pending_cmds.push_back(mk(CMD_DEL_AT, '0, 8'd1));
    pending_cmds.push_back(mk(CMD_INS_AT, 32'h7FFF_FFFF, '0));
    pending_cmds.push_back(mk(CMD_INS_AT, 32'h8000_0000, 8'd2));
    pending_cmds.push_back(mk(CMD_INS_AT, 32'h8000_0000, 8'd1));
    pending_cmds.push_back(mk(CMD_INS_FRONT, 32'h7FFF_FFFF, 8'hFF));
    pending_cmds.push_back(mk(CMD_INS_BACK, 32'hFFFF_FFFF, '0));
    pending_cmds.push_back(mk(CMD_NOP, '0, '0));
    for (int i = 0; i < 14; i++) pending_cmds.push_back(mk(CMD_INS_AT, $urandom, 8'd2));
    pending_cmds.push_back(mk(CMD_INS_FRONT, '0, '0));    // full
    pending_cmds.push_back(mk(CMD_INS_AT, 32'd1, '0));    // full beats bad position
    pending_cmds.push_back(mk(CMD_DUMP, '0, '0));
    pending_cmds.push_back(mk(CMD_DEL_AT, '0, 8'd17));
    pending_cmds.push_back(mk(CMD_DEL_AT, '0, 8'd16));
    pending_cmds.push_back(mk(CMD_DEL_AT, '0, '0));
    est = 15;
    for (int i = 0; i < N_RANDOM; i++) begin
      cmd_word_t c;
      c = rand_cmd(est);
      if (c.command <= CMD_INS_AT && est < DEPTH) est++;
      else if (c.command >= CMD_DEL_FRONT && c.command <= CMD_DEL_AT && est > 0) est--;
      pending_cmds.push_back(c);
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    fork
      begin
        repeat (200) @(posedge clk);
        quiet_phase = 1'b1;
        repeat (600) @(posedge clk);
        quiet_phase = 1'b0;
      end
    join_none
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    while (start || busy || expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("positional_list_engine regression: pass");
    else
      $display("positional_list_engine regression: fail");
    $finish;
  end

endmodule

/* files.f */
design/ple_pkg.sv
design/ple_mem.sv
design/positional_list_engine.sv
design/ple_checker.sv
sim/positional_list_engine_tb.sv
